// ===== design/hla_pkg.sv =====
// Shared types, codes and constant functions of the Hough line accumulator.
// Holds the beat structs, the control bundles and the fixed-point sine used
// to build the angle tables. Depends on nothing.
package hla_pkg;

  // Operation codes of an input beat.
  localparam logic OP_VOTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RHO_STEP     = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE    = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD    = 2'd2;
  localparam logic [1:0] CFG_MAX_DISTANCE = 2'd3;

  // Register reset values.
  localparam logic [9:0]  RHO_STEP_RST     = 10'd32;
  localparam logic [8:0]  TOLERANCE_RST    = 9'd15;
  localparam logic [11:0] THRESHOLD_RST    = 12'd100;
  localparam logic [10:0] MAX_DISTANCE_RST = 11'd1449;

  // Reciprocal of the bin width is kept as floor(2^RECIP_SHIFT / step).
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;

  typedef struct packed {
    logic       operation;
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [9:0] rho_bin;
    logic [5:0] angle_index;
    logic       last;
  } out_item_t;

  typedef enum logic {
    KIND_VOTE,
    KIND_CLEAR
  } item_kind_t;

  // Entry of the queue between the front and the back.
  typedef struct packed {
    item_kind_t kind;
    logic [9:0] row;
    logic [9:0] col;
  } qitem_t;

  // Effective configuration as seen by the voting pipeline.
  typedef struct packed {
    logic [9:0]  step;
    logic [8:0]  tol;
    logic [11:0] thr;
    logic [14:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [9:0] rho;
    logic [5:0] angle;
  } hit_t;

  typedef struct packed {
    logic ins;
    logic emit;
  } sort_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_RUN,
    BK_DRAIN,
    BK_EMIT
  } back_state_t;

  // Sine of r/16384 of a quarter turn in Q1.15, Taylor series to x^11 in Q30.
  function automatic logic signed [16:0] quarter_sine(input longint r);
    longint x;
    longint x2;
    longint t3;
    longint t5;
    longint t7;
    longint t9;
    longint t11;
    longint s;
    longint q;
    x   = (r * 64'sd1686629713) >>> 14;
    x2  = (x * x) >>> 30;
    t3  = ((x * x2) >>> 30) / 6;
    t5  = ((t3 * x2) >>> 30) / 20;
    t7  = ((t5 * x2) >>> 30) / 42;
    t9  = ((t7 * x2) >>> 30) / 72;
    t11 = ((t9 * x2) >>> 30) / 110;
    s   = x - t3 + t5 - t7 + t9 - t11;
    if (s < 0) begin
      s = 0;
    end
    q = (s + 16384) >>> 15;
    if (q > 32768) begin
      q = 32768;
    end
    return 17'(q);
  endfunction

  // Sine of phase p in 1/65536 of a turn, Q1.15.
  function automatic logic signed [16:0] phase_sine(input longint p);
    longint quad;
    longint r;
    logic signed [16:0] v;
    quad = (p >>> 14) & 3;
    r    = p & 16383;
    if ((quad & 1) != 0) begin
      v = quarter_sine(16384 - r);
    end else begin
      v = quarter_sine(r);
    end
    return ((quad & 2) != 0) ? -v : v;
  endfunction

endpackage

// ===== design/hla_front.sv =====
// Front end of the Hough line accumulator: takes input beats, drops votes
// of zero pixels and queues clear and vote work in a two-entry queue.
// Depends on hla_pkg.
module hla_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hla_pkg::in_item_t in_data,
  output logic             q_valid,
  output hla_pkg::qitem_t  q_item,
  input  logic             q_pop
);
  import hla_pkg::*;

  qitem_t     slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       keep;
  logic       push;
  qitem_t     entry;

  // Classify the beat: a clear always enters, a vote only with a nonzero pixel.
  always_comb begin
    keep        = (in_data.operation == OP_CLEAR) || (in_data.pixel != 8'd0);
    entry.kind  = (in_data.operation == OP_CLEAR) ? KIND_CLEAR : KIND_VOTE;
    entry.row   = in_data.row;
    entry.col   = in_data.col;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= entry;
    end
  end

endmodule

// ===== design/hla_recip.sv =====
// Bit-serial reciprocal of the bin width for the Hough line accumulator.
// Produces floor(2^RECIP_SHIFT / step), one quotient bit per cycle.
// Depends on hla_pkg.
module hla_recip (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [9:0]                        step,
  output logic                              busy,
  output logic [hla_pkg::RECIP_BITS-1:0]    recip
);
  import hla_pkg::*;

  localparam logic [4:0] TOP_BIT = 5'(RECIP_SHIFT);

  logic                  busy_r;
  logic [4:0]            bit_r;
  logic [9:0]            rem_r;
  logic [RECIP_BITS-1:0] quo_r;
  logic [10:0]           trial;
  logic                  fits;

  // Restoring division of a single set bit by the step.
  always_comb begin
    trial = {rem_r, (bit_r == TOP_BIT)};
    fits  = (trial >= {1'b0, step});
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      bit_r  <= TOP_BIT;
      rem_r  <= 10'd0;
    end else if (busy_r) begin
      rem_r <= fits ? 10'(trial - {1'b0, step}) : trial[9:0];
      bit_r <= bit_r - 5'd1;
      if (bit_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient shift register.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      quo_r <= {quo_r[RECIP_BITS-2:0], fits};
    end
  end

  assign busy  = busy_r;
  assign recip = quo_r;

endmodule

// ===== design/hla_sort.sv =====
// Result ordering for the Hough line accumulator: keeps the lines found for
// one pixel sorted by bin as they arrive and sends them out through an output
// register. Depends on hla_pkg.
module hla_sort #(
  parameter int NUM_ANGLES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hla_pkg::sort_ctl_t   ctl,
  input  hla_pkg::hit_t        hit,
  output logic                 empty,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hla_pkg::out_item_t   out_data
);
  import hla_pkg::*;

  localparam int CW = $clog2(NUM_ANGLES + 1);

  hit_t            ent_r   [NUM_ANGLES];
  hit_t            ent_nxt [NUM_ANGLES];
  logic [NUM_ANGLES-1:0] gt;
  logic [CW-1:0]   cnt_r;
  logic            shift;
  logic            ov_r;
  out_item_t       od_r;

  assign shift = ctl.emit && (cnt_r != CW'(0)) && (!ov_r || out_ready);
  assign empty = (cnt_r == CW'(0));

  // An entry ranks after the new line if it is unused or has a larger bin.
  always_comb begin
    for (int i = 0; i < NUM_ANGLES; i++) begin
      gt[i] = (CW'(i) >= cnt_r) || (ent_r[i].rho > hit.rho);
    end
  end

  // Per entry: insert, shift down on insert, or shift up on send.
  for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_ent
    if (g == 0) begin : g_head
      always_comb begin
        if (ctl.ins) begin
          ent_nxt[g] = gt[g] ? hit : ent_r[g];
        end else if (shift) begin
          ent_nxt[g] = (NUM_ANGLES > 1) ? ent_r[(g + 1) % NUM_ANGLES] : ent_r[g];
        end else begin
          ent_nxt[g] = ent_r[g];
        end
      end
    end else if (g == NUM_ANGLES - 1) begin : g_tail
      always_comb begin
        if (ctl.ins) begin
          ent_nxt[g] = gt[g-1] ? ent_r[g-1] : (gt[g] ? hit : ent_r[g]);
        end else begin
          ent_nxt[g] = ent_r[g];
        end
      end
    end else begin : g_mid
      always_comb begin
        if (ctl.ins) begin
          ent_nxt[g] = gt[g-1] ? ent_r[g-1] : (gt[g] ? hit : ent_r[g]);
        end else if (shift) begin
          ent_nxt[g] = ent_r[g+1];
        end else begin
          ent_nxt[g] = ent_r[g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // Fill count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(0);
      ov_r  <= 1'b0;
    end else begin
      if (ctl.ins) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (shift) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (shift) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (shift) begin
      od_r.rho_bin     <= ent_r[0].rho;
      od_r.angle_index <= ent_r[0].angle;
      od_r.last        <= (cnt_r == CW'(1));
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== design/hla_back.sv =====
// Voting engine of the Hough line accumulator: one angle per cycle through a
// distance pipeline and a read-modify-write of the vote memory, plus the
// clearing pass. Depends on hla_pkg.
module hla_back #(
  parameter int NUM_ANGLES = 64,
  parameter int RHO_BINS   = 1024,
  parameter int COUNT_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hla_pkg::cfg_t                  cfg,
  input  logic [hla_pkg::RECIP_BITS-1:0] recip,
  input  logic                           recip_busy,
  input  logic                           q_valid,
  input  hla_pkg::qitem_t                q_item,
  output logic                           q_pop,
  output hla_pkg::hit_t                  hit,
  output hla_pkg::sort_ctl_t             sort_ctl,
  input  logic                           sort_empty
);
  import hla_pkg::*;

  localparam int AB    = $clog2(NUM_ANGLES);
  localparam int RB    = $clog2(RHO_BINS);
  localparam int AW    = RB + AB;
  localparam int DEPTH = RHO_BINS * (2 ** AB);
  localparam int EW    = COUNT_BITS + 1;
  localparam logic [AW-1:0]         LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AB-1:0]         LAST_ANG  = AB'(NUM_ANGLES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Angle tables built at elaboration.
  logic signed [16:0] cos_tbl [NUM_ANGLES];
  logic signed [16:0] sin_tbl [NUM_ANGLES];

  for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_tbl
    localparam longint PHASE = (longint'(g) * 65536) / NUM_ANGLES;
    localparam logic signed [16:0] CV = phase_sine((PHASE + 16384) % 65536);
    localparam logic signed [16:0] SV = phase_sine(PHASE);
    assign cos_tbl[g] = CV;
    assign sin_tbl[g] = SV;
  end

  back_state_t   state_r, state_nxt;
  logic [AB-1:0] ang_r;
  logic [AW-1:0] sweep_r;
  logic [9:0]    row_r, col_r;
  logic          issue;
  logic          clearing;
  logic          emit;

  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [AB-1:0] a1_r, a2_r, a3_r, a4_r, a5_r, a6_r;
  logic signed [27:0] pc1_r, ps1_r;
  logic signed [17:0] d2_r, d3_r, d4_r;
  logic [15:0]   n2_r, n3_r, n4_r;
  logic [42:0]   m3_r;
  logic [15:0]   q4_r;
  logic [16:0]   pr4_r;
  logic [AW-1:0] addr5_r, addr6_r;
  logic [9:0]    rho5_r, rho6_r;
  logic [EW-1:0] rd_r;

  // Sequencer: pop work, sweep on clear, issue angles, drain, send results.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    clearing  = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && !recip_busy) begin
          q_pop     = 1'b1;
          state_nxt = (q_item.kind == KIND_CLEAR) ? BK_CLEAR : BK_RUN;
        end
      end
      BK_CLEAR: begin
        clearing = 1'b1;
        if (sweep_r == LAST_ADDR) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_RUN: begin
        issue = 1'b1;
        if (ang_r == LAST_ANG) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!(v1_r || v2_r || v3_r || v4_r || v5_r || v6_r)) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        emit = 1'b1;
        if (sort_empty) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      sweep_r <= '0;
      ang_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        sweep_r <= '0;
        ang_r   <= '0;
      end else begin
        if (clearing) begin
          sweep_r <= sweep_r + AW'(1);
        end
        if (issue) begin
          ang_r <= ang_r + AB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      row_r <= q_item.row;
      col_r <= q_item.col;
    end
  end

  // Pipeline valid bits.
  logic ok5;
  logic wr_vote;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r && ok5;
      v6_r <= v5_r;
    end
  end

  // Stage 1: column times cosine and row times sine.
  logic signed [27:0] col_x, row_x, cos_x, sin_x;
  always_comb begin
    col_x = {18'd0, col_r};
    row_x = {18'd0, row_r};
    cos_x = {{11{cos_tbl[ang_r][16]}}, cos_tbl[ang_r]};
    sin_x = {{11{sin_tbl[ang_r][16]}}, sin_tbl[ang_r]};
  end

  always_ff @(posedge clk) begin
    a1_r  <= ang_r;
    pc1_r <= col_x * cos_x;
    ps1_r <= row_x * sin_x;
  end

  // Stage 2: distance in sixteenths, rounded half up; offset for the bin.
  logic signed [28:0] sum2;
  logic signed [17:0] d2;
  logic [15:0]        n2;
  always_comb begin
    sum2 = {pc1_r[27], pc1_r} + {ps1_r[27], ps1_r} + 29'sd1024;
    d2   = sum2[28:11];
    n2   = d2[17] ? 16'd0 : (d2[15:0] + {7'd0, cfg.step[9:1]});
  end

  always_ff @(posedge clk) begin
    a2_r <= a1_r;
    d2_r <= d2;
    n2_r <= n2;
  end

  // Stage 3: multiply by the reciprocal of the bin width.
  always_ff @(posedge clk) begin
    a3_r <= a2_r;
    d3_r <= d2_r;
    n3_r <= n2_r;
    m3_r <= {27'd0, n2_r} * {16'd0, recip};
  end

  // Stage 4: estimated bin and its distance.
  logic [15:0] q3;
  assign q3 = m3_r[RECIP_SHIFT+15:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    a4_r  <= a3_r;
    d4_r  <= d3_r;
    n4_r  <= n3_r;
    q4_r  <= q3;
    pr4_r <= {1'b0, q3} * {7'd0, cfg.step};
  end

  // Stage 5: correct the estimate by one and test the window and range.
  logic [16:0]        rem5;
  logic               up5;
  logic [16:0]        rho5;
  logic [17:0]        rs5;
  logic signed [18:0] diff5;
  logic [18:0]        abs5;
  always_comb begin
    rem5  = {1'b0, n4_r} - pr4_r;
    up5   = (rem5 >= {7'd0, cfg.step});
    rho5  = {1'b0, q4_r} + {16'd0, up5};
    rs5   = {1'b0, pr4_r} + (up5 ? {8'd0, cfg.step} : 18'd0);
    diff5 = $signed({1'b0, rs5}) - $signed({d4_r[17], d4_r});
    abs5  = diff5[18] ? 19'(-diff5) : 19'(diff5);
    ok5   = (abs5 <= {10'd0, cfg.tol}) && (rho5 < 17'(RHO_BINS))
            && (rs5 < {3'd0, cfg.limit});
  end

  always_ff @(posedge clk) begin
    a5_r    <= a4_r;
    addr5_r <= {rho5[RB-1:0], a4_r};
    rho5_r  <= 10'(rho5);
  end

  // Stage 6: vote memory read, then update and write back.
  logic [EW-1:0] mem [DEPTH];
  logic          done6;
  logic [COUNT_BITS-1:0] cnt6, inc6;
  logic          reach6;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  always_comb begin
    done6   = rd_r[COUNT_BITS];
    cnt6    = rd_r[COUNT_BITS-1:0];
    inc6    = (cnt6 == COUNT_MAX) ? cnt6 : cnt6 + COUNT_BITS'(1);
    reach6  = (32'(inc6) >= 32'(cfg.thr));
    wr_vote = v6_r && !done6;
    we      = clearing || wr_vote;
    wa      = clearing ? sweep_r : addr6_r;
    wd      = clearing ? '0 : {reach6, inc6};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[addr5_r];
  end

  always_ff @(posedge clk) begin
    a6_r    <= a5_r;
    addr6_r <= addr5_r;
    rho6_r  <= rho5_r;
  end

  assign hit.rho       = rho6_r;
  assign hit.angle     = 6'(a6_r);
  assign sort_ctl.ins  = wr_vote && reach6;
  assign sort_ctl.emit = emit;

endmodule

// ===== design/hough_line_accumulator.sv =====
// Hough line accumulator top level: configuration registers, the front queue,
// the reciprocal unit, the voting engine and the result sorter.
// Depends on hla_pkg, hla_front, hla_recip, hla_back and hla_sort.
//
// Each edge pixel with a nonzero value votes once per angle: the engine takes
// one angle per cycle through a six-stage distance pipeline ending in a
// read-modify-write of the vote memory, and after the pipeline drains it
// hands out the reported lines, held while out_ready is low. Zero-pixel beats
// are absorbed by the input queue and take no engine time. A clear beat, and
// reset, run a clearing pass over all RHO_BINS times 2^ceil(log2(NUM_ANGLES))
// words of the vote memory (65536 at the default sizes); a write to rho_step
// starts a bit-serial reciprocal computation that must end before the next
// vote starts. Lines of one pixel leave sorted by bin, then angle, with last
// set on the final beat.
module hough_line_accumulator #(
  parameter int NUM_ANGLES = 64,
  parameter int RHO_BINS   = 1024,
  parameter int COUNT_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hla_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hla_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import hla_pkg::*;

  logic [9:0]  rho_step_r;
  logic [8:0]  tolerance_r;
  logic [11:0] threshold_r;
  logic [10:0] max_distance_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_step_r     <= RHO_STEP_RST;
      tolerance_r    <= TOLERANCE_RST;
      threshold_r    <= THRESHOLD_RST;
      max_distance_r <= MAX_DISTANCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RHO_STEP:     rho_step_r     <= cfg_data[9:0];
        CFG_TOLERANCE:    tolerance_r    <= cfg_data[8:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_data[11:0];
        CFG_MAX_DISTANCE: max_distance_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Effective settings: step at least one, window below half a step.
  cfg_t       cfg;
  logic [8:0] half_lim;
  always_comb begin
    cfg.step  = (rho_step_r == 10'd0) ? 10'd1 : rho_step_r;
    half_lim  = 9'((cfg.step - 10'd1) >> 1);
    cfg.tol   = (tolerance_r > half_lim) ? half_lim : tolerance_r;
    cfg.thr   = threshold_r;
    cfg.limit = {max_distance_r, 4'd0};
  end

  logic                  q_valid;
  qitem_t                q_item;
  logic                  q_pop;
  logic                  recip_busy;
  logic [RECIP_BITS-1:0] recip;
  hit_t                  hit;
  sort_ctl_t             sort_ctl;
  logic                  sort_empty;

  hla_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  hla_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we && (cfg_index == CFG_RHO_STEP)),
    .step  (cfg.step),
    .busy  (recip_busy),
    .recip (recip)
  );

  hla_back #(
    .NUM_ANGLES (NUM_ANGLES),
    .RHO_BINS   (RHO_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .recip      (recip),
    .recip_busy (recip_busy),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .hit        (hit),
    .sort_ctl   (sort_ctl),
    .sort_empty (sort_empty)
  );

  hla_sort #(
    .NUM_ANGLES (NUM_ANGLES)
  ) u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sort_ctl),
    .hit       (hit),
    .empty     (sort_empty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/hla_checker.sv =====
// Watches the beats of the Hough line accumulator, predicts the reported lines
// and compares them with what the block sends out.
// Depends on hla_pkg for the beat structs and the register indexes.
module hla_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  hla_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  hla_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output int                 failures,
  output int                 lines_pending
);
  import hla_pkg::*;

  localparam int ANGLES = 64;
  localparam int BINS = 1024;
  localparam int CELLS = ANGLES * BINS;
  localparam int COUNT_TOP = 4095;

  // Shadow registers and vote memory.
  logic [9:0]  step_r;
  logic [8:0]  tol_r;
  logic [11:0] thr_r;
  logic [10:0] maxd_r;
  logic [11:0] tally [CELLS];
  bit          frozen [CELLS];
  int          sin_q [ANGLES];
  int          cos_q [ANGLES];
  out_item_t   lines_due [$];
  int          fail_count = 0;

  // Quarter-wave sine, Taylor series to x^11 in Q30, rounded to Q1.15.
  function automatic int quarter_wave(longint r);
    longint x, x2, t3, t5, t7, t9, t11, s, q;
    x   = (r * 64'sd1686629713) >>> 14;
    x2  = (x * x) >>> 30;
    t3  = ((x * x2) >>> 30) / 6;
    t5  = ((t3 * x2) >>> 30) / 20;
    t7  = ((t5 * x2) >>> 30) / 42;
    t9  = ((t7 * x2) >>> 30) / 72;
    t11 = ((t9 * x2) >>> 30) / 110;
    s   = x - t3 + t5 - t7 + t9 - t11;
    if (s < 0) s = 0;
    q = (s + 16384) >>> 15;
    if (q > 32768) q = 32768;
    return int'(q);
  endfunction

  // Full-turn sine from the quarter wave by symmetry; p in 1/65536 turn.
  function automatic int wave(longint p);
    longint quad, r;
    int v;
    quad = (p >> 14) & 3;
    r    = p & 16383;
    v    = quad[0] ? quarter_wave(16384 - r) : quarter_wave(r);
    return quad[1] ? -v : v;
  endfunction

  initial begin
    for (int a = 0; a < ANGLES; a++) begin
      sin_q[a] = wave(a * 1024);
      cos_q[a] = wave((a * 1024 + 16384) & 65535);
    end
  end

  function automatic void wipe_votes();
    for (int i = 0; i < CELLS; i++) begin
      tally[i] = '0;
      frozen[i] = 1'b0;
    end
  endfunction

  // Vote with one pixel over all angles and queue the lines it completes.
  function automatic void cast_votes(in_item_t it);
    longint stp, tol, lim, acc, d, rho, diff;
    int idx, n, j;
    int hit_rho [ANGLES];
    int hit_ang [ANGLES];
    int kr, ka;
    out_item_t line;
    n = 0;
    stp = (step_r == 0) ? 1 : longint'(step_r);
    tol = longint'(tol_r);
    if (tol > (stp - 1) / 2) tol = (stp - 1) / 2;
    lim = longint'(maxd_r) * 16;
    for (int a = 0; a < ANGLES; a++) begin
      acc = longint'(it.col) * cos_q[a] + longint'(it.row) * sin_q[a];
      d = ((acc + 1024 + 134217728) >>> 11) - 65536;
      rho = (d < 0) ? 0 : (d + stp / 2) / stp;
      diff = rho * stp - d;
      if (diff < 0) diff = -diff;
      if (diff > tol || rho >= BINS || rho * stp >= lim) continue;
      idx = int'(rho) * ANGLES + a;
      if (frozen[idx]) continue;
      if (tally[idx] < COUNT_TOP) tally[idx] = tally[idx] + 12'd1;
      if (tally[idx] >= thr_r) begin
        frozen[idx] = 1'b1;
        hit_rho[n] = int'(rho);
        hit_ang[n] = a;
        n++;
      end
    end
    // Lines leave ordered by bin; angle order is kept within a bin.
    for (int i = 1; i < n; i++) begin
      kr = hit_rho[i];
      ka = hit_ang[i];
      j = i - 1;
      while (j >= 0 && hit_rho[j] > kr) begin
        hit_rho[j + 1] = hit_rho[j];
        hit_ang[j + 1] = hit_ang[j];
        j--;
      end
      hit_rho[j + 1] = kr;
      hit_ang[j + 1] = ka;
    end
    for (int i = 0; i < n; i++) begin
      line.rho_bin = 10'(hit_rho[i]);
      line.angle_index = 6'(hit_ang[i]);
      line.last = (i == n - 1);
      lines_due = {lines_due, line};
    end
  endfunction

  assign failures = fail_count;

  // Track the registers, predict on each input beat, check each output beat.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      step_r <= RHO_STEP_RST;
      tol_r  <= TOLERANCE_RST;
      thr_r  <= THRESHOLD_RST;
      maxd_r <= MAX_DISTANCE_RST;
      wipe_votes();
      lines_due.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RHO_STEP:     step_r <= cfg_data[9:0];
          CFG_TOLERANCE:    tol_r  <= cfg_data[8:0];
          CFG_THRESHOLD:    thr_r  <= cfg_data[11:0];
          CFG_MAX_DISTANCE: maxd_r <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_CLEAR) begin
          wipe_votes();
        end else if (in_data.pixel != 0) begin
          cast_votes(in_data);
        end
      end
      if (out_valid && out_ready) begin
        if (lines_due.size() == 0) begin
          $error("unexpected line beat rho_bin=%0d angle_index=%0d",
                 out_data.rho_bin, out_data.angle_index);
          fail_count++;
        end else begin
          want = lines_due.pop_front();
          if (out_data.rho_bin !== want.rho_bin) begin
            $error("rho_bin expected %0d actual %0d", want.rho_bin, out_data.rho_bin);
            fail_count++;
          end
          if (out_data.angle_index !== want.angle_index) begin
            $error("angle_index expected %0d actual %0d",
                   want.angle_index, out_data.angle_index);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
    lines_pending <= lines_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the Hough line accumulator testbench: clock, reset, register
// settings, pixel stimulus and the verdict.
// Depends on hla_pkg, hough_line_accumulator and hla_checker.
module testbench;
  import hla_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_RHO_STEP;
  logic [11:0] cfg_data = '0;
  int         failures;
  int         lines_pending;
  int         send_idle = 0;
  int         recv_idle = 0;
  logic [9:0] hot_row [4];
  logic [9:0] hot_col [4];

  always #5 clk = ~clk;

  hough_line_accumulator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hla_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .lines_pending(lines_pending)
  );

  // Receiver stalls at the current idle rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Offer one beat, idling first at the current rate, and hold it until taken.
  task automatic send_beat(input logic op, input int r, input int c, input int pix);
    in_item_t it;
    it.operation = op;
    it.row = 10'(r);
    it.col = 10'(c);
    it.pixel = 8'(pix);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every predicted line arrive, then outwait a clearing pass.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lines_pending != 0) @(posedge clk);
    repeat (70000) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 12'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int stp, input int tol, input int thr, input int maxd);
    settle();
    write_reg(CFG_RHO_STEP, stp);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_MAX_DISTANCE, maxd);
    repeat (40) @(posedge clk);
  endtask

  // Mostly pixels clustered around a few hot spots so bins fill up,
  // with some scattered pixels, blank pixels and a rare clear.
  task automatic random_pixels(input int count, input int span);
    int pick;
    int k;
    for (int i = 0; i < 4; i++) begin
      hot_row[i] = 10'($urandom_range(1023));
      hot_col[i] = 10'($urandom_range(1023));
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      k = $urandom_range(3);
      if (pick < 70) begin
        send_beat(OP_VOTE, (hot_row[k] + $urandom_range(span)) & 1023,
                  (hot_col[k] + $urandom_range(span)) & 1023, $urandom_range(255, 1));
      end else if (pick < 92) begin
        send_beat(OP_VOTE, $urandom_range(1023), $urandom_range(1023), $urandom_range(255));
      end else if (pick < 98) begin
        send_beat(OP_VOTE, $urandom_range(1023), $urandom_range(1023), 0);
      end else begin
        send_beat(OP_CLEAR, $urandom_range(1023), $urandom_range(1023), $urandom_range(255));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the first idle mix.
    send_idle = 26;
    recv_idle = 71;
    set_regs(32, 15, 2, 1449);
    send_beat(OP_VOTE, 0, 0, 255);
    send_beat(OP_VOTE, 0, 0, 1);
    send_beat(OP_VOTE, 0, 0, 128);
    send_beat(OP_VOTE, 1023, 1023, 0);
    send_beat(OP_VOTE, 1023, 1023, 8'h55);
    send_beat(OP_VOTE, 1023, 1023, 8'hAA);
    send_beat(OP_VOTE, 512, 0, 7);
    send_beat(OP_VOTE, 512, 0, 7);
    send_beat(OP_VOTE, 0, 512, 64);
    send_beat(OP_VOTE, 0, 512, 2);
    send_beat(OP_VOTE, 341, 682, 16);
    send_beat(OP_CLEAR, 1023, 1023, 255);
    send_beat(OP_VOTE, 0, 0, 8'hAA);
    send_beat(OP_VOTE, 0, 0, 8'h55);
    send_beat(OP_VOTE, 1023, 0, 3);
    send_beat(OP_VOTE, 1023, 0, 4);

    // Smallest step with an oversized window, tiny image, every vote reports.
    set_regs(0, 511, 1, 1);
    random_pixels(12, 3);
    set_regs(1, 511, 1, 2);
    random_pixels(13, 3);

    // Widest step: full window with a threshold never reached, then no window.
    send_idle = 71;
    recv_idle = 26;
    set_regs(1023, 511, 4095, 1449);
    random_pixels(10, 8);
    set_regs(1023, 0, 1, 1449);
    random_pixels(15, 8);

    // Narrow bins on a smaller image.
    set_regs(5, 2, 3, 700);
    random_pixels(30, 2);

    send_idle = 0;
    recv_idle = 0;
    set_regs(17, 8, 2, 1449);
    random_pixels(16, 4);

    @(negedge clk);
    in_valid <= 1'b0;
    while (lines_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/hla_pkg.sv
design/hla_front.sv
design/hla_recip.sv
design/hla_sort.sv
design/hla_back.sv
design/hough_line_accumulator.sv
test/hla_checker.sv
test/testbench.sv
